FILE: hdl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; lpfd_out_stage and the top level import this package.
`default_nettype none

package lpfd_pkg;

  // Header layout: one command byte, four stream id bytes, two length bytes
  localparam logic [2:0] HC_COMMAND  = 3'd0;
  localparam logic [2:0] HC_ID_FIRST = 3'd1;
  localparam logic [2:0] HC_ID_LAST  = 3'd4;
  localparam logic [2:0] HC_LEN_HIGH = 3'd5;
  localparam logic [2:0] HC_LEN_LOW  = 3'd6;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  frame_command;
    logic [31:0] frame_stream_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        bad_command;
    logic        last_of_frame;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/lpfd_stream_if.sv
// Valid/ready stream channel carrying one item of type item_t.
// Depends on nothing; instantiated with the item types of lpfd_pkg.
`default_nettype none

interface lpfd_stream_if #(
  parameter type item_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/lpfd_out_stage.sv
// Output register of the deframer: holds one result until the sink takes it.
// Depends on lpfd_pkg and lpfd_stream_if.
`default_nettype none

module lpfd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire lpfd_pkg::result_t load_data,
  output logic                 load_ready,
  lpfd_stream_if.source        results
);
  import lpfd_pkg::*;

  logic    valid;
  result_t data;

  // Room for a new result when empty or when the held one leaves this cycle
  assign load_ready = !valid || results.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign results.valid   = valid;
  assign results.payload = data;

  // A held result must not be overwritten while stalled
  assert property (@(posedge clk) disable iff (rst)
    (valid && !results.ready) |-> !load)
    else $error("result overwritten while stalled");

  // A load always leaves a result on offer
  assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded result not presented");

  // Stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    (valid && !results.ready) |=> (valid && $stable(data)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: hdl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer: header parsing and payload count.
// Depends on lpfd_pkg, lpfd_stream_if and lpfd_out_stage.
//
//  channel   dir  handshake      item
//  bytes     in   valid/ready    in_byte, one raw stream byte
//  results   out  valid/ready    header or payload result (result_t)
//  cfg       in   cfg_we         cfg_wdata -> highest_valid_command
//
// One byte is accepted per clock unless results stalls; a result appears on
// results in the cycle after the byte causing it (seventh header or any payload byte).
// The single output register decouples the sides: a byte is taken whenever that
// register is empty or is being emptied in the same cycle.
// rst is synchronous: parser returns to the start of a header, register to 10.
// No clearing pass; the block is ready straight out of reset.
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  lpfd_stream_if.sink     bytes,
  lpfd_stream_if.source   results,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import lpfd_pkg::*;

  logic [7:0]  highest_valid_command;
  logic [2:0]  header_count;
  logic [2:0]  header_count_next;
  logic [7:0]  held_command;
  logic [7:0]  held_command_next;
  logic [31:0] held_stream_id;
  logic [31:0] held_stream_id_next;
  logic [15:0] held_length;
  logic [15:0] held_length_next;
  logic [15:0] payload_left;
  logic [15:0] payload_left_next;

  logic        accept;
  logic        in_payload;
  logic        produce;
  logic        load_ready;
  logic [7:0]  b;
  result_t     res;

  assign bytes.ready = load_ready;
  assign accept      = bytes.valid && load_ready;
  assign b           = bytes.payload.in_byte;
  assign in_payload  = (payload_left != 16'd0);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      highest_valid_command <= 8'd10;
    end else if (cfg_we) begin
      highest_valid_command <= cfg_wdata;
    end
  end

  // Parser next state and result for the current byte
  always_comb begin
    header_count_next   = header_count;
    held_command_next   = held_command;
    held_stream_id_next = held_stream_id;
    held_length_next    = held_length;
    payload_left_next   = payload_left;
    produce             = 1'b0;

    res.item_kind       = KIND_HEADER;
    res.payload_byte    = 8'd0;
    res.last_of_frame   = 1'b0;

    if (in_payload) begin
      payload_left_next = payload_left - 16'd1;
      produce           = 1'b1;
      res.item_kind     = KIND_PAYLOAD;
      res.payload_byte  = b;
      res.last_of_frame = (payload_left == 16'd1);
    end else begin
      case (header_count) inside
        HC_COMMAND:                held_command_next   = b;
        [HC_ID_FIRST:HC_ID_LAST]:  held_stream_id_next = {held_stream_id[23:0], b};
        HC_LEN_HIGH:               held_length_next    = {8'd0, b};
        default:                   held_length_next    = {held_length[7:0], b};
      endcase

      if (header_count >= HC_LEN_LOW) begin
        header_count_next = HC_COMMAND;
        payload_left_next = held_length_next;
        produce           = 1'b1;
        res.last_of_frame = (held_length_next == 16'd0);
      end else begin
        header_count_next = header_count + 3'd1;
      end
    end

    res.frame_command   = held_command_next;
    res.frame_stream_id = held_stream_id_next;
    res.frame_length    = held_length_next;
    res.bad_command     = (held_command_next > highest_valid_command);
  end

  // Parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= HC_COMMAND;
      payload_left <= 16'd0;
    end else if (accept) begin
      header_count <= header_count_next;
      payload_left <= payload_left_next;
    end
  end

  // Held header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      held_command   <= 8'd0;
      held_stream_id <= 32'd0;
      held_length    <= 16'd0;
    end else if (accept) begin
      held_command   <= held_command_next;
      held_stream_id <= held_stream_id_next;
      held_length    <= held_length_next;
    end
  end

  lpfd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && produce),
    .load_data  (res),
    .load_ready (load_ready),
    .results    (results)
  );

  // Header counter stays within the seven header bytes
  assert property (@(posedge clk) disable iff (rst)
    header_count <= HC_LEN_LOW)
    else $error("header counter out of range");

  // Payload phase only starts on a header boundary
  assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_count == HC_COMMAND))
    else $error("payload phase with partial header");

  // Each payload byte gives a payload result next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_payload) |=>
      (results.valid && results.payload.item_kind == KIND_PAYLOAD))
    else $error("payload byte without payload result");

  // Final header byte gives a header result next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && !in_payload && header_count == HC_LEN_LOW) |=>
      (results.valid && results.payload.item_kind == KIND_HEADER))
    else $error("completed header without header result");

  // Header bytes before the last give nothing
  assert property (@(posedge clk) disable iff (rst)
    (accept && !in_payload && header_count != HC_LEN_LOW) |-> !produce)
    else $error("result from partial header");

endmodule

`default_nettype wire
